/* hw/rtl/rgbhsl_pkg.sv */
package rgbhsl_pkg;

    localparam int CHANNEL_BITS_DEF = 8;

endpackage

/* hw/rtl/rgbhsl_front.sv */
// Stage 0: finds the extremes and forms the luminance, the gray flag, the numerators and the denominators.
module rgbhsl_front #(
    parameter int CB = rgbhsl_pkg::CHANNEL_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [CB-1:0]   i_r,
    input  logic [CB-1:0]   i_g,
    input  logic [CB-1:0]   i_b,
    output logic            o_vld,
    output logic            o_gray,
    output logic [CB-1:0]   o_lum,
    output logic [CB+2:0]   o_hnum,
    output logic [CB+2:0]   o_hden,
    output logic [CB-1:0]   o_snum,
    output logic [CB:0]     o_sden
);
    localparam logic [CB:0] FULL = {1'b0, {CB{1'b1}}};

    logic [CB-1:0] mx, mn, d;
    logic [CB:0]   s;
    logic [CB+2:0] six_d, n;
    logic signed [CB+3:0] nt;

    logic          r_vld, r_gray;
    logic [CB-1:0] r_lum, r_snum;
    logic [CB+2:0] r_hnum, r_hden;
    logic [CB:0]   r_sden;

    always_comb begin
        mx = (i_r >= i_g) ? i_r : i_g;
        if (i_b > mx) mx = i_b;
        mn = (i_r <= i_g) ? i_r : i_g;
        if (i_b < mn) mn = i_b;
        d = mx - mn;
        s = {1'b0, mx} + {1'b0, mn};
        six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        if (i_r == mx) begin
            nt = $signed({4'b0, i_g}) - $signed({4'b0, i_b});
        end else if (i_g == mx) begin
            nt = $signed({4'b0, i_b}) - $signed({4'b0, i_r}) + $signed({3'b0, d, 1'b0});
        end else begin
            nt = $signed({4'b0, i_r}) - $signed({4'b0, i_g}) + $signed({2'b0, d, 2'b0});
        end
        if (nt < 0) nt = nt + $signed({1'b0, six_d});
        n = nt[CB+2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_gray <= (d == '0);
        r_lum  <= s[CB:1];
        r_snum <= d;
        r_sden <= (s <= FULL) ? s : ({FULL[CB-1:0], 1'b0} - s);
        r_hnum <= n;
        r_hden <= six_d;
    end

    assign o_vld  = r_vld;
    assign o_gray = r_gray;
    assign o_lum  = r_lum;
    assign o_hnum = r_hnum;
    assign o_hden = r_hden;
    assign o_snum = r_snum;
    assign o_sden = r_sden;
endmodule

/* hw/rtl/rgbhsl_div.sv */
// Pipelined restoring divider for floor(num * (2^CB - 1) / den), one
// quotient bit per stage. The quotient is known to fit in CB bits.
module rgbhsl_div #(
    parameter int CB = rgbhsl_pkg::CHANNEL_BITS_DEF,
    parameter int NW = CB + 3
) (
    input  logic            i_clk,
    input  logic [NW-1:0]   i_num,
    input  logic [NW-1:0]   i_den,
    output logic [CB-1:0]   o_quo
);
    localparam int PW = NW + CB;

    logic [PW-1:0] r_rem [CB+1];
    logic [NW-1:0] r_den [CB+1];
    logic [CB-1:0] r_quo [CB+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {i_num, {CB{1'b0}}} - {{CB{1'b0}}, i_num};
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar k = 0; k < CB; k++) begin : g_stage
        localparam int SH = CB - 1 - k;
        logic [PW+CB-1:0] dsh;
        assign dsh = {{CB{1'b0}}, {PW-NW{1'b0}}, r_den[k]} << SH;
        always_ff @(posedge i_clk) begin
            if ({{CB{1'b0}}, r_rem[k]} >= dsh) begin
                r_rem[k+1] <= r_rem[k] - dsh[PW-1:0];
                r_quo[k+1] <= r_quo[k] | (CB'(1) << SH);
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_quo[k+1] <= r_quo[k];
            end
            r_den[k+1] <= r_den[k];
        end
    end

    assign o_quo = r_quo[CB];
endmodule

/* hw/rtl/rgb_to_hsl_converter.sv */
// Channel  | Direction | Ports
// pixel    | in        | i_start, o_busy, i_red, i_green, i_blue
// result   | out       | o_strobe, o_hue, o_saturation, o_luminosity
//
// One pixel is accepted every cycle; o_busy is always low.
// The path runs through one front stage, the product stage
// and one stage per quotient bit of the two dividers.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
module rgb_to_hsl_converter #(
    parameter int CHANNEL_BITS = rgbhsl_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_strobe,
    output logic [CHANNEL_BITS-1:0] o_hue,
    output logic [CHANNEL_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0] o_luminosity
);
    localparam int CB = CHANNEL_BITS;
    localparam int LAT = CB + 1;

    logic          f_vld, f_gray;
    logic [CB-1:0] f_lum, f_snum, hq, sq;
    logic [CB+2:0] f_hnum, f_hden;
    logic [CB:0]   f_sden;

    logic [LAT-1:0] r_vld, r_gray;
    logic [CB-1:0]  r_lum [LAT];

    rgbhsl_front #(.CB(CB)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_start),
        .i_r(i_red), .i_g(i_green), .i_b(i_blue),
        .o_vld(f_vld), .o_gray(f_gray), .o_lum(f_lum),
        .o_hnum(f_hnum), .o_hden(f_hden), .o_snum(f_snum), .o_sden(f_sden)
    );

    rgbhsl_div #(.CB(CB), .NW(CB + 3)) u_hdiv (
        .i_clk(i_clk), .i_num(f_hnum), .i_den(f_hden), .o_quo(hq)
    );

    rgbhsl_div #(.CB(CB), .NW(CB + 1)) u_sdiv (
        .i_clk(i_clk), .i_num({1'b0, f_snum}), .i_den(f_sden), .o_quo(sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], f_vld};
        end
        r_gray <= {r_gray[LAT-2:0], f_gray};
        r_lum[0] <= f_lum;
        for (int k = 1; k < LAT; k++) r_lum[k] <= r_lum[k-1];
    end

    assign o_busy       = 1'b0;
    assign o_strobe     = r_vld[LAT-1];
    assign o_hue        = r_gray[LAT-1] ? {CB{1'b1}} : hq;
    assign o_saturation = r_gray[LAT-1] ? '0 : sq;
    assign o_luminosity = r_lum[LAT-1];
endmodule

/* sim/tb_rgb_to_hsl_converter.sv */
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;

    localparam int CB = rgbhsl_pkg::CHANNEL_BITS_DEF;
    localparam int LATENCY = CB + 2;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CB-1:0] hue;
        logic [CB-1:0] sat;
        logic [CB-1:0] lum;
    } t_hsl;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    logic [CB-1:0] i_red = '0;
    logic [CB-1:0] i_green = '0;
    logic [CB-1:0] i_blue = '0;
    logic          o_busy;
    logic          o_strobe;
    logic [CB-1:0] o_hue;
    logic [CB-1:0] o_saturation;
    logic [CB-1:0] o_luminosity;

    t_pixel pending_pixels[$];
    t_hsl   expected_hsl[$];
    int     mismatches = 0;
    int     checked = 0;
    int     gap_left = 0;
    int     burst_left = 0;
    bit     feeding_done = 1'b0;

    rgb_to_hsl_converter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_strobe(o_strobe), .o_hue(o_hue), .o_saturation(o_saturation),
        .o_luminosity(o_luminosity)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_hsl rgb_to_hsl(t_pixel p);
        longint full, r, g, b, mx, mn, s, d, den, n, six_d;
        t_hsl res;
        full = (1 << CB) - 1;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        s = mx + mn;
        d = mx - mn;
        res.lum = CB'(s >> 1);
        if (d == 0) begin
            res.hue = CB'(full);
            res.sat = '0;
        end else begin
            six_d = 6 * d;
            den = (s <= full) ? s : (2 * full - s);
            res.sat = CB'((d * full) / den);
            // Red wins ties for the maximum, then green.
            if (r == mx) begin
                n = g - b;
            end else if (g == mx) begin
                n = b - r + 2 * d;
            end else begin
                n = r - g + 4 * d;
            end
            if (n < 0) n += six_d;
            if (n >= six_d) n -= six_d;
            res.hue = CB'((n * full) / six_d);
        end
        return res;
    endfunction

    function automatic t_pixel mk(int r, int g, int b);
        t_pixel p;
        p.red = CB'(r);
        p.green = CB'(g);
        p.blue = CB'(b);
        return p;
    endfunction

    // Sender: bursts of back-to-back transfers separated by random gaps.
    always @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            expected_hsl.push_back(rgb_to_hsl({i_red, i_green, i_blue}));
        end
        if (i_start && o_busy) begin
            // Hold the current transfer until it is taken.
        end else if (!i_rst_n || pending_pixels.size() == 0) begin
            i_start <= 1'b0;
            if (i_rst_n && pending_pixels.size() == 0) feeding_done <= 1'b1;
        end else if (gap_left > 0) begin
            i_start <= 1'b0;
            gap_left <= gap_left - 1;
        end else begin
            t_pixel p;
            p = pending_pixels.pop_front();
            i_start <= 1'b1;
            i_red <= p.red;
            i_green <= p.green;
            i_blue <= p.blue;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_hsl.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result hue=%0d", o_hue);
            end else begin
                t_hsl e;
                e = expected_hsl.pop_front();
                checked++;
                if (e.hue !== o_hue || e.sat !== o_saturation || e.lum !== o_luminosity)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected h=%0d s=%0d l=%0d got h=%0d s=%0d l=%0d",
                                 e.hue, e.sat, e.lum, o_hue, o_saturation, o_luminosity);
                end
            end
        end
    end

    initial begin
        int m;
        m = (1 << CB) - 1;
        pending_pixels.push_back(mk(0, 0, 0));
        pending_pixels.push_back(mk(m, m, m));
        pending_pixels.push_back(mk(128, 128, 128));
        pending_pixels.push_back(mk(m, 0, 0));
        pending_pixels.push_back(mk(0, m, 0));
        pending_pixels.push_back(mk(0, 0, m));
        pending_pixels.push_back(mk(m, m, 0));
        pending_pixels.push_back(mk(0, m, m));
        pending_pixels.push_back(mk(m, 0, m));
        pending_pixels.push_back(mk(m, 0, 1));
        pending_pixels.push_back(mk(1, 0, 0));
        pending_pixels.push_back(mk(m, m - 1, m - 1));
        pending_pixels.push_back(mk(128, 127, 127));
        pending_pixels.push_back(mk(127, 128, 128));
        pending_pixels.push_back(mk(200, 200, 10));
        pending_pixels.push_back(mk(10, 200, 200));
        pending_pixels.push_back(mk(200, 10, 200));
        pending_pixels.push_back(mk(170, 85, 0));
        pending_pixels.push_back(mk(85, 170, 255));
        pending_pixels.push_back(mk(m, 1, 0));
        for (int i = 0; i < 500; i++) begin
            case ($urandom_range(0, 4))
                0: begin
                    int v;
                    v = $urandom_range(0, m);
                    pending_pixels.push_back(mk(v, v, v));
                end
                1: begin
                    int v;
                    v = $urandom_range(0, m);
                    pending_pixels.push_back(mk(v, v, $urandom_range(0, m)));
                end
                default: pending_pixels.push_back(mk($urandom, $urandom, $urandom));
            endcase
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (feeding_done && expected_hsl.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Checked %0d pixels: primaries, grays, ties and random colors.", checked);
        if (mismatches == 0 && expected_hsl.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule
